// File: rtl/abkf_pkg.sv
// abkf_pkg: shared types and constants for the angle/bias kalman filter
// used by the controller, datapath and top level; no dependencies
package abkf_pkg;

	localparam int unsigned NOISE_W = 25;
	localparam int unsigned NUM_REGS = 6;
	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [2:0] {
		REG_X_ANGLE   = 3'd0,
		REG_X_BIAS    = 3'd1,
		REG_X_MEASURE = 3'd2,
		REG_Y_ANGLE   = 3'd3,
		REG_Y_BIAS    = 3'd4,
		REG_Y_MEASURE = 3'd5
	} reg_idx_t;

	localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 25'd16777;
	localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 25'd50332;
	localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 25'd503316;

	// sequencer steps
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PRED1,
		ST_PRED2,
		ST_PRED3,
		ST_DIVSET,
		ST_DIV0,
		ST_DIV1,
		ST_CORR1,
		ST_CORR2,
		ST_CORR3,
		ST_CORR4,
		ST_WRITE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PRED1,
		OP_PRED2,
		OP_PRED3,
		OP_DIVSET,
		OP_DIV0_START,
		OP_DIV1_START,
		OP_CORR1,
		OP_CORR2,
		OP_CORR3,
		OP_CORR4,
		OP_WRITE
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_status_t;

	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		logic signed [31:0] r;
		if (v > 72'sd2147483647) r = 32'sh7fffffff;
		else if (v < -72'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

// File: rtl/abkf_stream_if.sv
// abkf_stream_if: valid/ready channel interface with a generic payload
// depends on nothing
interface abkf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/angle_bias_kalman_filter_top.sv
// angle/bias kalman filter, one step per input transaction for one axis
// sequence: load, predict, two serial divider passes for the gains, correct, write
// a new transaction is accepted only in idle, once the previous step has been written
// one result register sits on the output; a result not yet taken holds the last step
// arst_n clears all axis states to zero and loads the noise registers with defaults
module angle_bias_kalman_filter_top #(
	parameter int unsigned NUM_AXES = 2
) (
	input  logic clk,
	input  logic arst_n,
	abkf_stream_if.sink   in_if,
	abkf_stream_if.source out_if,
	input  logic                           cfg_we,
	input  logic [abkf_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [abkf_pkg::NOISE_W-1:0]   cfg_data
);
	abkf_pkg::dp_cmd_t    cmd;
	abkf_pkg::dp_status_t sts;
	logic in_ready, out_load, out_valid_q, res_axis;
	logic signed [31:0] res_angle;
	logic out_axis_q;
	logic signed [31:0] out_angle_q;

	assign in_if.ready = in_ready;

	abkf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_if.valid), .in_ready(in_ready),
		.out_load(out_load), .out_free(!out_valid_q || out_if.ready),
		.cmd(cmd), .sts(sts)
	);

	abkf_dp #(.NUM_AXES(NUM_AXES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_fire(in_if.valid && in_ready), .in_axis(in_if.data.axis),
		.in_meas(in_if.data.measured_angle), .in_rate(in_if.data.rate),
		.in_step(in_if.data.time_step),
		.cfg_en(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.res_axis(res_axis), .res_angle(res_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_load) out_valid_q <= 1'b1;
		else if (out_if.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_axis_q  <= res_axis;
			out_angle_q <= res_angle;
		end
	end

	assign out_if.valid = out_valid_q;
	assign out_if.data.result_axis = out_axis_q;
	assign out_if.data.filtered_angle = out_angle_q;
endmodule

// File: rtl/abkf_div.sv
// abkf_div: radix-2 restoring signed divider, one quotient bit per cycle
// depends on abkf_pkg (sat32)
module abkf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [33:0] den,
	output logic               busy,
	output logic signed [31:0] quo
);
	localparam int unsigned NB = 56;
	localparam int unsigned CNT_W = 6;

	logic [NB-1:0]    dvd_q;
	logic [NB-1:0]    rem_q;
	logic [33:0]      dmag_q;
	logic             neg_q;
	logic             zero_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NB-1:0]    rem_sh;
	logic [NB:0]      diff;
	logic signed [71:0] sq;

	assign rem_sh = {rem_q[NB-2:0], dvd_q[NB-1]};
	assign diff   = {1'b0, rem_sh} - {{(NB-33){1'b0}}, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= CNT_W'(NB - 1);
		end else if (busy) begin
			if (cnt_q == '0) busy <= 1'b0;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= num[31] ? NB'(-({{24{num[31]}}, num, 24'd0})) : NB'({num, 24'd0});
			rem_q  <= '0;
			dmag_q <= den[33] ? 34'(-den) : den;
			neg_q  <= num[31] ^ den[33];
			zero_q <= (den == '0);
		end else if (busy) begin
			dvd_q <= {dvd_q[NB-2:0], 1'b0};
			if (!diff[NB]) begin
				rem_q <= diff[NB-1:0];
				dvd_q <= {dvd_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({16'd0, dvd_q}) : $signed({16'd0, dvd_q});
		quo = zero_q ? 32'sd0 : abkf_pkg::sat32(sq);
	end
endmodule

// File: rtl/abkf_ctrl.sv
// abkf_ctrl: sequencer for one filter step
// depends on abkf_pkg (state_t, dp_cmd_t, dp_status_t)
module abkf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_load,
	input  logic                   out_free,
	output abkf_pkg::dp_cmd_t      cmd,
	input  abkf_pkg::dp_status_t   sts
);
	abkf_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= abkf_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			abkf_pkg::ST_IDLE:   if (in_valid) state_d = abkf_pkg::ST_LOAD;
			abkf_pkg::ST_LOAD:   state_d = abkf_pkg::ST_PRED1;
			abkf_pkg::ST_PRED1:  state_d = abkf_pkg::ST_PRED2;
			abkf_pkg::ST_PRED2:  state_d = abkf_pkg::ST_PRED3;
			abkf_pkg::ST_PRED3:  state_d = abkf_pkg::ST_DIVSET;
			abkf_pkg::ST_DIVSET: state_d = abkf_pkg::ST_DIV0;
			abkf_pkg::ST_DIV0:   if (!sts.div_busy) state_d = abkf_pkg::ST_DIV1;
			abkf_pkg::ST_DIV1:   if (!sts.div_busy) state_d = abkf_pkg::ST_CORR1;
			abkf_pkg::ST_CORR1:  state_d = abkf_pkg::ST_CORR2;
			abkf_pkg::ST_CORR2:  state_d = abkf_pkg::ST_CORR3;
			abkf_pkg::ST_CORR3:  state_d = abkf_pkg::ST_CORR4;
			abkf_pkg::ST_CORR4:  state_d = abkf_pkg::ST_WRITE;
			abkf_pkg::ST_WRITE:  if (out_free) state_d = abkf_pkg::ST_IDLE;
			default:             state_d = abkf_pkg::ST_IDLE;
		endcase
	end

	// divider start pulses fire on entry: DIV0 entered from DIVSET, DIV1 when DIV0 done
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		cmd.op   = abkf_pkg::OP_NONE;
		unique case (state_q)
			abkf_pkg::ST_IDLE:   in_ready = 1'b1;
			abkf_pkg::ST_LOAD:   cmd.op = abkf_pkg::OP_LOAD;
			abkf_pkg::ST_PRED1:  cmd.op = abkf_pkg::OP_PRED1;
			abkf_pkg::ST_PRED2:  cmd.op = abkf_pkg::OP_PRED2;
			abkf_pkg::ST_PRED3:  cmd.op = abkf_pkg::OP_PRED3;
			abkf_pkg::ST_DIVSET: cmd.op = abkf_pkg::OP_DIV0_START;
			abkf_pkg::ST_DIV0:   if (!sts.div_busy) cmd.op = abkf_pkg::OP_DIV1_START;
			abkf_pkg::ST_DIV1:   if (!sts.div_busy) cmd.op = abkf_pkg::OP_DIVSET;
			abkf_pkg::ST_CORR1:  cmd.op = abkf_pkg::OP_CORR1;
			abkf_pkg::ST_CORR2:  cmd.op = abkf_pkg::OP_CORR2;
			abkf_pkg::ST_CORR3:  cmd.op = abkf_pkg::OP_CORR3;
			abkf_pkg::ST_CORR4:  cmd.op = abkf_pkg::OP_CORR4;
			// hold here until the output register can take the result
			abkf_pkg::ST_WRITE: begin
				if (out_free) begin
					cmd.op   = abkf_pkg::OP_WRITE;
					out_load = 1'b1;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == abkf_pkg::ST_IDLE)
		else $error("accept outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result loaded over pending output");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == abkf_pkg::ST_CORR1) |-> !sts.div_busy)
		else $error("correction began before gains ready");
endmodule

// File: rtl/abkf_dp.sv
// abkf_dp: per-axis state registers, noise bank, predict/correct arithmetic
// depends on abkf_pkg and abkf_div
module abkf_dp #(
	parameter int unsigned NUM_AXES = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  abkf_pkg::dp_cmd_t        cmd,
	output abkf_pkg::dp_status_t     sts,
	input  logic                     in_fire,
	input  logic                     in_axis,
	input  logic signed [31:0]       in_meas,
	input  logic signed [31:0]       in_rate,
	input  logic [7:0]               in_step,
	input  logic                     cfg_en,
	input  logic [abkf_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [abkf_pkg::NOISE_W-1:0]   cfg_data,
	output logic                     res_axis,
	output logic signed [31:0]       res_angle
);
	localparam int unsigned AX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	logic signed [31:0] ang_q [NUM_AXES];
	logic signed [31:0] bias_q [NUM_AXES];
	logic signed [31:0] aa_q [NUM_AXES];
	logic signed [31:0] ab_q [NUM_AXES];
	logic signed [31:0] ba_q [NUM_AXES];
	logic signed [31:0] bb_q [NUM_AXES];
	logic [abkf_pkg::NOISE_W-1:0] noise_q [abkf_pkg::NUM_REGS];

	logic               axis_q;
	logic signed [31:0] meas_q, rate_q;
	logic [7:0]         d_q;
	logic signed [31:0] ang_w, bias_w, aa_w, ab_w, ba_w, bb_w;
	logic [abkf_pkg::NOISE_W-1:0] qa_q, qb_q, r_q;
	logic signed [31:0] pa_q, pab_q, pba_q, pbb_q, k0_q, k1_q;
	logic signed [63:0] t1_q, t2_q;
	logic signed [33:0] y_q;
	logic signed [71:0] m1_q, m2_q;
	logic signed [33:0] s_w;
	logic               div_start;
	logic signed [31:0] div_num, quo;
	logic               div_busy;

	logic signed [71:0] x2;

	logic [AX_W-1:0] in_sel;
	always_comb begin
		if (32'(in_axis) >= NUM_AXES) in_sel = AX_W'(NUM_AXES - 1);
		else in_sel = AX_W'(in_axis);
	end

	logic [AX_W-1:0] a_q;

	// noise bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q[abkf_pkg::REG_X_ANGLE]   <= abkf_pkg::ANGLE_NOISE_RST;
			noise_q[abkf_pkg::REG_X_BIAS]    <= abkf_pkg::BIAS_NOISE_RST;
			noise_q[abkf_pkg::REG_X_MEASURE] <= abkf_pkg::MEASURE_NOISE_RST;
			noise_q[abkf_pkg::REG_Y_ANGLE]   <= abkf_pkg::ANGLE_NOISE_RST;
			noise_q[abkf_pkg::REG_Y_BIAS]    <= abkf_pkg::BIAS_NOISE_RST;
			noise_q[abkf_pkg::REG_Y_MEASURE] <= abkf_pkg::MEASURE_NOISE_RST;
		end else if (cfg_en && cfg_idx < abkf_pkg::REG_IDX_W'(abkf_pkg::NUM_REGS)) begin
			noise_q[cfg_idx] <= cfg_data;
		end
	end

	assign ang_w  = ang_q[a_q];
	assign bias_w = bias_q[a_q];
	assign aa_w   = aa_q[a_q];
	assign ab_w   = ab_q[a_q];
	assign ba_w   = ba_q[a_q];
	assign bb_w   = bb_q[a_q];

	assign s_w = 34'(pa_q) + 34'($signed({1'b0, r_q}));
	assign div_start = (cmd.op == abkf_pkg::OP_DIV0_START) ||
		(cmd.op == abkf_pkg::OP_DIV1_START);
	assign div_num = (cmd.op == abkf_pkg::OP_DIV0_START) ? pa_q : pba_q;

	abkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(s_w), .busy(div_busy), .quo(quo)
	);
	assign sts.div_busy = div_busy;

	// floor(v / 2^24) is an arithmetic shift
	always_comb begin
		x2 = m2_q >>> 24;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			axis_q <= in_axis;
			a_q    <= in_sel;
			meas_q <= in_meas;
			rate_q <= in_rate;
			d_q    <= in_step;
		end
		case (cmd.op)
			abkf_pkg::OP_LOAD: begin
				qa_q <= axis_q ? noise_q[abkf_pkg::REG_Y_ANGLE] : noise_q[abkf_pkg::REG_X_ANGLE];
				qb_q <= axis_q ? noise_q[abkf_pkg::REG_Y_BIAS] : noise_q[abkf_pkg::REG_X_BIAS];
				r_q  <= axis_q ? noise_q[abkf_pkg::REG_Y_MEASURE] :
					noise_q[abkf_pkg::REG_X_MEASURE];
				// d*bb and d*(rate-bias)
				t1_q <= 64'($signed({1'b0, d_q})) * 64'(bb_w);
				t2_q <= 64'($signed({1'b0, d_q})) * (64'(rate_q) - 64'(bias_w));
			end
			abkf_pkg::OP_PRED1: begin
				pab_q <= abkf_pkg::sat32(72'(ab_w) - 72'(t1_q));
				pba_q <= abkf_pkg::sat32(72'(ba_w) - 72'(t1_q));
				pbb_q <= abkf_pkg::sat32(72'(bb_w) + 72'($signed({1'b0, qb_q})));
				m1_q  <= 72'(ang_w) + 72'(t2_q);
				t1_q  <= t1_q - 64'(ba_w) - 64'(ab_w);
			end
			abkf_pkg::OP_PRED2: begin
				m2_q <= 72'($signed({1'b0, d_q})) * 72'(t1_q);
				m1_q <= 72'(abkf_pkg::sat32(m1_q));
			end
			abkf_pkg::OP_PRED3: begin
				pa_q <= abkf_pkg::sat32(72'(aa_w) + m2_q + 72'($signed({1'b0, qa_q})));
				y_q  <= 34'(meas_q) - 34'($signed(m1_q[31:0]));
			end
			abkf_pkg::OP_DIV1_START: k0_q <= quo;
			abkf_pkg::OP_DIVSET:     k1_q <= quo;
			abkf_pkg::OP_CORR1: begin
				m2_q <= 72'(k0_q) * 72'(y_q);
				t1_q <= 64'(k1_q) * 64'(y_q);
			end
			abkf_pkg::OP_CORR2: begin
				m1_q <= 72'(abkf_pkg::sat32(72'($signed(m1_q[31:0])) + x2));
				m2_q <= 72'(t1_q);
			end
			abkf_pkg::OP_CORR3: begin
				t2_q <= 64'(abkf_pkg::sat32(72'(bias_w) + x2));
				m2_q <= 72'(k0_q) * 72'(pa_q);
				t1_q <= 64'(k0_q) * 64'(pab_q);
			end
			abkf_pkg::OP_CORR4: begin
				pa_q  <= abkf_pkg::sat32(72'(pa_q) - x2);
				pab_q <= abkf_pkg::sat32(72'(pab_q) - (72'(t1_q) >>> 24));
				m2_q  <= 72'(k1_q) * 72'(pa_q);
				t1_q  <= 64'(k1_q) * 64'(pab_q);
			end
			default: ;
		endcase
	end

	// state update: only WRITE changes the bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				ang_q[i] <= '0; bias_q[i] <= '0; aa_q[i] <= '0;
				ab_q[i] <= '0; ba_q[i] <= '0; bb_q[i] <= '0;
			end
		end else if (cmd.op == abkf_pkg::OP_WRITE) begin
			ang_q[a_q]  <= m1_q[31:0];
			bias_q[a_q] <= t2_q[31:0];
			aa_q[a_q]   <= pa_q;
			ab_q[a_q]   <= pab_q;
			ba_q[a_q]   <= abkf_pkg::sat32(72'(pba_q) - x2);
			bb_q[a_q]   <= abkf_pkg::sat32(72'(pbb_q) - (72'(t1_q) >>> 24));
		end
	end

	assign res_axis  = axis_q;
	assign res_angle = m1_q[31:0];
endmodule
